// ===== rtl/tnq_pkg.sv =====
// ----------------------------------------------------------------------------
// Tone note queue package
// Shared widths, codes, reset values and controller command type.
// ----------------------------------------------------------------------------
package tnq_pkg;

    // Default depth of the note queue.
    localparam int QUEUE_DEPTH_DEF = 9;

    // Fixed field widths.
    localparam int LEN_W    = 16;
    localparam int TONE_W   = 16;
    localparam int TIME_W   = 17;
    localparam int DEC_W    = 10;
    localparam int STAT_W   = 2;
    localparam int NOTES_W  = 4;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

    // Reset value of the tick step register.
    localparam logic [DEC_W-1:0] TICK_DEC_RESET = 10'd10;

    // Item kinds carried in tuser.
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Add status codes.
    localparam logic [STAT_W-1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_QRY_IDLE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_QRY_PLAY  = 2'd3;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic step;      // apply the presented word and load the result register
    } t_ctrl_cmd;

endpackage

// ===== rtl/tnq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tone note queue controller
// Handshake state machine that owns the result register's occupancy.
// ----------------------------------------------------------------------------
module tnq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output tnq_pkg::t_ctrl_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;

    // A new word may enter whenever the result register is empty or being emptied.
    assign o_s_tready = (r_state == S_IDLE) || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == S_HOLD);
    assign o_cmd.step = w_accept;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_accept) begin
                    n_state = S_HOLD;
                end else if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A held result that is not taken must never be overwritten.
    a_hold_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && !i_m_tready) |-> !o_cmd.step)
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/tnq_dpath.sv =====
// ----------------------------------------------------------------------------
// Tone note queue datapath
// Shifting note queue, countdown, tick step register and result register.
// ----------------------------------------------------------------------------
module tnq_dpath #(
    parameter int QUEUE_DEPTH = tnq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tnq_pkg::t_ctrl_cmd          i_cmd,
    input  logic                        i_kind,
    input  logic [tnq_pkg::LEN_W-1:0]   i_len,
    input  logic [tnq_pkg::TONE_W-1:0]  i_tone,
    input  logic                        i_cfg_wr_en,
    input  logic [tnq_pkg::DEC_W-1:0]   i_cfg_wr_data,
    output logic [tnq_pkg::STAT_W-1:0]  o_add_status,
    output logic                        o_playing,
    output logic [tnq_pkg::TONE_W-1:0]  o_current_tone,
    output logic [tnq_pkg::NOTES_W-1:0] o_queued_notes
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [tnq_pkg::LEN_W-1:0]  r_len  [QUEUE_DEPTH];
    logic [tnq_pkg::TONE_W-1:0] r_tone [QUEUE_DEPTH];
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic [tnq_pkg::TIME_W-1:0] r_time;
    logic [tnq_pkg::TIME_W-1:0] n_time;
    logic [tnq_pkg::DEC_W-1:0]  r_dec;

    logic [tnq_pkg::STAT_W-1:0] r_status;
    logic                       r_playing;
    logic [tnq_pkg::TONE_W-1:0] r_head_tone;
    logic [CNT_W-1:0]           r_notes;

    logic                       w_is_note;
    logic                       w_push;
    logic                       w_pop;
    logic                       w_empty;
    logic [tnq_pkg::LEN_W-1:0]  w_second_len;
    logic [tnq_pkg::TONE_W-1:0] w_second_tone;
    logic [tnq_pkg::TIME_W-1:0] w_dec_ext;
    logic [tnq_pkg::STAT_W-1:0] n_status;
    logic                       n_playing;
    logic [tnq_pkg::TONE_W-1:0] n_head_tone;

    assign w_empty   = (r_count == '0);
    assign w_is_note = (i_len != '0) && (i_tone != '0);
    assign w_dec_ext = tnq_pkg::TIME_W'(r_dec);

    // Entry behind the head, or zero where the queue holds a single slot.
    always_comb begin
        w_second_len  = '0;
        w_second_tone = '0;
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (i == 1) begin
                w_second_len  = r_len[i];
                w_second_tone = r_tone[i];
            end
        end
    end

    always_comb begin
        w_push      = 1'b0;
        w_pop       = 1'b0;
        n_count     = r_count;
        n_time      = r_time;
        n_status    = tnq_pkg::ST_ACCEPTED;
        n_playing   = 1'b0;
        n_head_tone = w_empty ? '0 : r_tone[0];
        if (i_kind == tnq_pkg::CMD_ADD) begin
            if (w_is_note) begin
                if (r_count != CNT_FULL) begin
                    w_push  = 1'b1;
                    n_count = r_count + 1'b1;
                    if (w_empty) begin
                        n_time      = tnq_pkg::TIME_W'(i_len);
                        n_head_tone = i_tone;
                    end
                end else begin
                    n_status = tnq_pkg::ST_FULL;
                end
            end else begin
                n_status = (r_time != '0) ? tnq_pkg::ST_QRY_PLAY : tnq_pkg::ST_QRY_IDLE;
            end
        end else if (!w_empty) begin
            n_playing = 1'b1;
            if (r_time <= w_dec_ext) begin
                // The head note has run out: the next one takes over the countdown.
                w_pop   = 1'b1;
                n_count = r_count - 1'b1;
                if (r_count > CNT_W'(1)) begin
                    n_time      = tnq_pkg::TIME_W'(w_second_len);
                    n_head_tone = w_second_tone;
                end else begin
                    n_time      = '0;
                    n_head_tone = '0;
                end
            end else begin
                n_time = r_time - w_dec_ext;
            end
        end
    end

    // Queue slots: written at the fill position, shifted towards the head on a pop.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                r_len[i]  <= r_len[i+1];
                r_tone[i] <= r_tone[i+1];
            end
        end
        if (i_cmd.step && w_push) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (r_count[IDX_W-1:0] == IDX_W'(i)) begin
                    r_len[i]  <= i_len;
                    r_tone[i] <= i_tone;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_time  <= '0;
            r_dec   <= tnq_pkg::TICK_DEC_RESET;
        end else begin
            if (i_cmd.step) begin
                r_count <= n_count;
                r_time  <= n_time;
            end
            if (i_cfg_wr_en) begin
                r_dec <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_status    <= n_status;
            r_playing   <= n_playing;
            r_head_tone <= n_head_tone;
            r_notes     <= n_count;
        end
    end

    assign o_add_status   = r_status;
    assign o_playing      = r_playing;
    assign o_current_tone = r_head_tone;
    assign o_queued_notes = tnq_pkg::NOTES_W'(r_notes);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("note count beyond queue depth");

    a_time_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) == (r_time != '0))
        else $error("countdown out of step with queue occupancy");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && i_kind == tnq_pkg::CMD_ADD && r_count == CNT_FULL)
        |=> (r_count == CNT_FULL))
        else $error("add on a full queue changed the count");

endmodule

// ===== rtl/tone_note_queue_sequencer.sv =====
// ----------------------------------------------------------------------------
// Tone note queue sequencer
// Queue of notes (length, tone) with a countdown on the head note.
// ----------------------------------------------------------------------------
// The result word is valid in the cycle after the input word is taken.
// Throughput: one word per cycle; the result register frees in the same cycle
// that downstream takes it, so o_s_tready stays high while i_m_tready is high.
// Reset (synchronous, i_rst_n low): queue emptied, countdown cleared, result
// register empty and the tick step set to 10; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tone_note_queue_sequencer #(
    parameter int QUEUE_DEPTH = tnq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [15:0] note_length, [31:16] note_tone
    input  logic [tnq_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [0] cmd: 0 add or query, 1 tick
    input  logic                          i_s_tuser,
    // Result stream.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [1:0] add_status, [2] playing, [18:3] current_tone, [22:19] queued_notes,
    // [23] zero
    output logic [tnq_pkg::M_DATA_W-1:0]  o_m_tdata,
    // Tick step register.
    input  logic                          i_cfg_wr_en,
    input  logic [tnq_pkg::DEC_W-1:0]     i_cfg_wr_data
);

    // The controller decides when a word is taken and when the result register
    // is occupied; the datapath holds all other state and computes the next
    // state and the result word in the cycle the word is taken.
    tnq_pkg::t_ctrl_cmd            w_cmd;
    logic [tnq_pkg::STAT_W-1:0]    w_add_status;
    logic                          w_playing;
    logic [tnq_pkg::TONE_W-1:0]    w_current_tone;
    logic [tnq_pkg::NOTES_W-1:0]   w_queued_notes;

    tnq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    tnq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_kind         (i_s_tuser),
        .i_len          (i_s_tdata[15:0]),
        .i_tone         (i_s_tdata[31:16]),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_add_status   (w_add_status),
        .o_playing      (w_playing),
        .o_current_tone (w_current_tone),
        .o_queued_notes (w_queued_notes)
    );

    // Fields packed from the lowest bit up, padded to whole bytes.
    assign o_m_tdata = {1'b0, w_queued_notes, w_current_tone, w_playing, w_add_status};

endmodule
